/* rtl/upc_pkg.sv */
// Shared types, codes and character helpers for the percent codec.
package upc_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic       DIR_ENCODE = 1'b0;
	localparam logic       DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Escape tracking while decoding
	typedef enum logic [2:0] {
		PH_NONE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// Up to three result bytes for one input byte, b0 goes out first
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       last;
	} res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic is_plain(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h21, 8'h28, 8'h29, 8'h2A, 8'h2E, 8'h5F, 8'h7E});
	endfunction

	function automatic logic [7:0] hex_up(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
	endfunction

endpackage

/* rtl/upc_xlate.sv */
// Translation logic: one input byte plus escape state to up to three result bytes.
module upc_xlate import upc_pkg::*; (
	input  logic       dir,
	input  phase_t     phase,
	input  logic [7:0] held,
	input  in_item_t   item,
	output res_t       res,
	output phase_t     phase_nxt,
	output logic       held_we
);

	logic [7:0] b;
	logic       last;
	logic       b_hex;
	logic       b_pct;

	assign b     = item.in_byte;
	assign last  = item.in_last;
	assign b_hex = is_hex(b);
	assign b_pct = (b == PCT_CHAR) && !last;

	always_comb begin
		res       = '0;
		res.last  = last;
		phase_nxt = PH_NONE;
		held_we   = 1'b0;
		if (dir == DIR_ENCODE) begin
			if (is_plain(b)) begin
				res.cnt = 2'd1;
				res.b0  = b;
			end else begin
				res.cnt = 2'd3;
				res.b0  = PCT_CHAR;
				res.b1  = hex_up(b[7:4]);
				res.b2  = hex_up(b[3:0]);
			end
		end else begin
			case (phase)
				PH_DIGIT: begin
					if (b_hex) begin
						res.cnt = 2'd1;
						res.b0  = {hex_val(held), hex_val(b)};
					end else begin
						// flush the broken escape literally, then re-examine b
						res.b0 = PCT_CHAR;
						res.b1 = held;
						res.b2 = b;
						if (b_pct) begin
							res.cnt   = 2'd2;
							phase_nxt = PH_PCT;
						end else begin
							res.cnt = 2'd3;
						end
					end
				end
				PH_PCT: begin
					if (b_hex && !last) begin
						held_we   = 1'b1;
						phase_nxt = PH_DIGIT;
					end else begin
						res.b0 = PCT_CHAR;
						res.b1 = b;
						if (b_pct) begin
							res.cnt   = 2'd1;
							phase_nxt = PH_PCT;
						end else begin
							res.cnt = 2'd2;
						end
					end
				end
				default: begin
					if (b_pct) begin
						phase_nxt = PH_PCT;
					end else begin
						res.cnt = 2'd1;
						res.b0  = b;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/upc_obuf.sv */
// Result register that hands out the buffered bytes one transfer at a time.
module upc_obuf import upc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ld,
	input  res_t      res,
	output logic      free,
	output logic      dst_valid,
	input  logic      dst_ready,
	output out_item_t dst_data
);

	logic [1:0] cnt_s2;
	logic       last_s2;
	logic [7:0] b0_s2;
	logic [7:0] b1_s2;
	logic [7:0] b2_s2;
	logic       xfer;

	assign dst_valid         = (cnt_s2 != 2'd0);
	assign xfer              = dst_valid && dst_ready;
	assign free              = (cnt_s2 == 2'd0) || ((cnt_s2 == 2'd1) && dst_ready);
	assign dst_data.out_byte = b0_s2;
	assign dst_data.out_last = last_s2 && (cnt_s2 == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (ld) begin
			cnt_s2 <= res.cnt;
		end else if (xfer) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			b0_s2   <= res.b0;
			b1_s2   <= res.b1;
			b2_s2   <= res.b2;
			last_s2 <= res.last;
		end else if (xfer) begin
			b0_s2 <= b1_s2;
			b1_s2 <= b2_s2;
		end
	end

endmodule

/* rtl/url_percent_codec.sv */
// Top level of the streaming URL percent encoder / decoder.
// Bytes enter on the src channel, one transfer per byte, and leave on the dst
// channel one byte per transfer. A byte is captured in an input register, then
// translated combinationally into up to three result bytes held in the result
// register. With a free output the block moves one byte per clock; a byte that
// encodes to "%XY", or a decode flush of a broken escape, occupies the output
// for one transfer per result byte, and src_ready drops while the next byte waits. A decode
// that swallows a '%' or its first hex digit produces no transfer for that byte.
// The last marker goes out with the final byte that the last input produces; an
// input last byte always produces at least one. The direction register (0 encode,
// 1 decode) is written over the cfg channel, which is always ready; write it only
// while the block is idle. A write also drops any partially received escape.
module url_percent_codec import upc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_ready,
	output out_item_t dst_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	// input register
	in_item_t   data_s1;
	logic       valid_s1;
	// direction and escape state
	logic       dir_q;
	phase_t     phase_q;
	logic [7:0] held_q;

	res_t       res;
	phase_t     phase_nxt;
	logic       held_we;
	logic       obuf_free;
	logic       adv;
	logic       cfg_wr;

	// advance the input register into the result register when it frees up
	assign adv       = valid_s1 && obuf_free;
	assign src_ready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	// hold the payload until it moves on
	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			data_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_ENCODE;
			phase_q <= PH_NONE;
		end else if (cfg_wr) begin
			dir_q   <= cfg_data;
			phase_q <= PH_NONE;
		end else if (adv) begin
			phase_q <= phase_nxt;
		end
	end

	// held hex digit is only read after it has been written
	always_ff @(posedge clk) begin
		if (adv && held_we) begin
			held_q <= data_s1.in_byte;
		end
	end

	upc_xlate u_xlate (
		.dir       (dir_q),
		.phase     (phase_q),
		.held      (held_q),
		.item      (data_s1),
		.res       (res),
		.phase_nxt (phase_nxt),
		.held_we   (held_we)
	);

	upc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (adv),
		.res       (res),
		.free      (obuf_free),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	// encoding never leaves an escape in progress
	a_enc_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !cfg_wr && dir_q == DIR_ENCODE) |=> (phase_q == PH_NONE))
		else $error("escape state held in encode mode");

	// a last byte closes any escape
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && data_s1.in_last) |=> (phase_q == PH_NONE))
		else $error("escape state survives end of string");

	// a stalled input register keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(data_s1)))
		else $error("input register lost or changed a byte");

	// a last input always yields a final output byte
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && data_s1.in_last) |-> (res.cnt != 2'd0))
		else $error("last input produced no output");

endmodule
